[rtl/jse_pkg.sv]
package jse_pkg;

  // longest escaped form of one code point: a surrogate pair of two escapes
  localparam int unsigned MAX_BYTES = 12;
  localparam int unsigned CNT_W     = 4;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [7:0]       byte_t;

  // item kinds on the input tuser
  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_POINT = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // register index, taken from paddr[2]
  localparam logic REG_ESC_UNICODE = 1'b0;
  localparam logic REG_QUOTE_SINGLE = 1'b1;

  // characters used by the escapes
  localparam byte_t CH_BSL = 8'h5C;
  localparam byte_t CH_U   = 8'h75;
  localparam byte_t CH_DQ  = 8'h22;
  localparam byte_t CH_SQ  = 8'h27;
  localparam byte_t CH_B   = 8'h62;
  localparam byte_t CH_T   = 8'h74;
  localparam byte_t CH_N   = 8'h6E;
  localparam byte_t CH_F   = 8'h66;
  localparam byte_t CH_R   = 8'h72;

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_SUR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SUR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
  localparam logic [20:0] CP_PLANE1  = 21'h010000;

  // escaped bytes of one item, byte 0 goes out first
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    cnt_t                      count;
  } enc_t;

  // uppercase hex digit
  function automatic byte_t hex_char(input logic [3:0] d);
    byte_t c;
    c = (d < 4'd10) ? (8'h30 + {4'b0, d}) : (8'h37 + {4'b0, d});
    return c;
  endfunction

  // \uXXXX, backslash in the lowest byte
  function automatic logic [5:0][7:0] u_escape(input logic [15:0] v);
    logic [5:0][7:0] e;
    e[0] = CH_BSL;
    e[1] = CH_U;
    e[2] = hex_char(v[15:12]);
    e[3] = hex_char(v[11:8]);
    e[4] = hex_char(v[7:4]);
    e[5] = hex_char(v[3:0]);
    return e;
  endfunction

endpackage

[rtl/jse_encoder.sv]
module jse_encoder
  import jse_pkg::*;
(
  input  action_t     action,
  input  logic [20:0] code_point,
  input  logic        esc_unicode,
  input  logic        quote_single,
  output enc_t        enc
);

  logic [20:0] cp;
  logic [20:0] cp_off;
  byte_t       quote;
  logic        is_low;

  // out-of-range values and surrogates become the replacement character
  assign cp = ((code_point > CP_MAX) ||
               ((code_point >= CP_SUR_LO) && (code_point <= CP_SUR_HI)))
              ? CP_REPLACE : code_point;
  assign cp_off = cp - CP_PLANE1;
  assign quote  = quote_single ? CH_SQ : CH_DQ;
  assign is_low = (cp[20:8] == 13'd0);

  // one code point to its escaped byte sequence
  always_comb begin
    enc.bytes = '0;
    enc.count = '0;
    unique case (action)
      ACT_OPEN, ACT_CLOSE: begin
        enc.bytes[0] = quote;
        enc.count    = cnt_t'(1);
      end
      ACT_POINT: begin
        priority if (is_low && (cp[7:0] == 8'h08)) begin
          enc.bytes[1:0] = {CH_B, CH_BSL};
          enc.count      = cnt_t'(2);
        end else if (is_low && (cp[7:0] == 8'h09)) begin
          enc.bytes[1:0] = {CH_T, CH_BSL};
          enc.count      = cnt_t'(2);
        end else if (is_low && (cp[7:0] == 8'h0A)) begin
          enc.bytes[1:0] = {CH_N, CH_BSL};
          enc.count      = cnt_t'(2);
        end else if (is_low && (cp[7:0] == 8'h0C)) begin
          enc.bytes[1:0] = {CH_F, CH_BSL};
          enc.count      = cnt_t'(2);
        end else if (is_low && (cp[7:0] == 8'h0D)) begin
          enc.bytes[1:0] = {CH_R, CH_BSL};
          enc.count      = cnt_t'(2);
        end else if (is_low && (cp[7:0] == CH_BSL)) begin
          enc.bytes[1:0] = {CH_BSL, CH_BSL};
          enc.count      = cnt_t'(2);
        end else if (is_low && (cp[7:0] == quote)) begin
          enc.bytes[1:0] = {quote, CH_BSL};
          enc.count      = cnt_t'(2);
        end else if (cp < 21'h20) begin
          enc.bytes[5:0] = u_escape(cp[15:0]);
          enc.count      = cnt_t'(6);
        end else if (cp < 21'h80) begin
          enc.bytes[0] = cp[7:0];
          enc.count    = cnt_t'(1);
        end else if (esc_unicode && (cp <= 21'h00FFFF)) begin
          enc.bytes[5:0] = u_escape(cp[15:0]);
          enc.count      = cnt_t'(6);
        end else if (esc_unicode) begin
          // surrogate pair
          enc.bytes[5:0]  = u_escape({6'b110110, cp_off[19:10]});
          enc.bytes[11:6] = u_escape({6'b110111, cp_off[9:0]});
          enc.count       = cnt_t'(12);
        end else if (cp < 21'h800) begin
          enc.bytes[0] = {3'b110, cp[10:6]};
          enc.bytes[1] = {2'b10, cp[5:0]};
          enc.count    = cnt_t'(2);
        end else if (cp < CP_PLANE1) begin
          enc.bytes[0] = {4'b1110, cp[15:12]};
          enc.bytes[1] = {2'b10, cp[11:6]};
          enc.bytes[2] = {2'b10, cp[5:0]};
          enc.count    = cnt_t'(3);
        end else begin
          enc.bytes[0] = {5'b11110, cp[20:18]};
          enc.bytes[1] = {2'b10, cp[17:12]};
          enc.bytes[2] = {2'b10, cp[11:6]};
          enc.bytes[3] = {2'b10, cp[5:0]};
          enc.count    = cnt_t'(4);
        end
      end
      ACT_NONE: begin
        enc.count = '0;
      end
      default: begin
        enc.count = '0;
      end
    endcase
  end

endmodule

[rtl/jse_byte_buffer.sv]
module jse_byte_buffer
  import jse_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  enc_t  enc,
  output logic  can_load,
  output logic  out_tvalid,
  input  logic  out_tready,
  output byte_t out_tdata,
  output logic  out_tlast
);

  logic [MAX_BYTES-1:0][7:0] bytes_r;
  cnt_t                      cnt_r;
  cnt_t                      idx_r;
  logic                      valid_r;
  logic                      fire;
  logic                      at_last;

  assign fire     = valid_r & out_tready;
  assign at_last  = ((idx_r + cnt_t'(1)) == cnt_r);
  assign can_load = ~valid_r | (fire & at_last);

  // current beat
  assign out_tvalid = valid_r;
  assign out_tdata  = bytes_r[idx_r];
  assign out_tlast  = at_last;

  // control: load a new sequence or step through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
      cnt_r   <= enc.count;
    end else if (fire) begin
      if (at_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + cnt_t'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= enc.bytes;
    end
  end

endmodule

[rtl/json_string_escaper_unit.sv]
// channel  | dir | handshake          | payload
// in       | in  | in_tvalid/tready   | tuser: action, tdata: code_point
// out      | out | out_tvalid/tready  | tdata: out_byte, tlast: last
// cfg      | in  | apb, pready high   | 0x0 esc_unicode, 0x4 quote_single
//
// an item yields 1 to 12 bytes, one output beat per byte; one-byte items
// flow at one per cycle while out_tready is high, longer escapes stall the input
// an accepted item goes through the input register, then the byte buffer
// rst_n is synchronous, active low; clears valid flags and both config registers
// an unused action is dropped from the input register and produces no beat
module json_string_escaper_unit
  import jse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] code_point, [23:21] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        esc_unicode_r;
  logic        quote_single_r;
  logic        cfg_wr;
  logic        in_valid_r;
  action_t     in_action_r;
  logic [20:0] in_cp_r;
  logic        in_move;
  logic        buf_load;
  logic        can_load;
  enc_t        enc;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = {31'b0, (cfg_paddr[2] == REG_QUOTE_SINGLE) ? quote_single_r
                                                                 : esc_unicode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_unicode_r  <= 1'b0;
      quote_single_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ESC_UNICODE:  esc_unicode_r  <= cfg_pwdata[0];
        REG_QUOTE_SINGLE: quote_single_r <= cfg_pwdata[0];
        default:          esc_unicode_r  <= esc_unicode_r;
      endcase
    end
  end

  // input register, freed when its item moves into the byte buffer or is dropped
  assign in_move   = in_valid_r & ((enc.count == '0) | can_load);
  assign buf_load  = in_move & (enc.count != '0);
  assign in_tready = ~in_valid_r | in_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (in_move) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= action_t'(in_tuser);
      in_cp_r     <= in_tdata[20:0];
    end
  end

  // escape logic
  jse_encoder u_encoder (
    .action         (in_action_r),
    .code_point     (in_cp_r),
    .esc_unicode    (esc_unicode_r),
    .quote_single   (quote_single_r),
    .enc            (enc)
  );

  // byte sequence output
  jse_byte_buffer u_byte_buffer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (buf_load),
    .enc        (enc),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // an empty input register always takes a beat
  a_in_ready_when_empty: assert property (
    @(posedge clk) disable iff (!rst_n) !in_valid_r |-> in_tready
  ) else $error("input register empty but not ready");

  // a one-byte item moved into a free buffer comes out as a single last beat
  a_single_byte_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    (buf_load && (enc.count == cnt_t'(1))) |=> (out_tvalid && out_tlast)
  ) else $error("single-byte item not presented as last beat");

  // a write to the escape register takes effect on the next cycle
  a_cfg_write: assert property (
    @(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_paddr[2] == REG_ESC_UNICODE)) |=> (esc_unicode_r == $past(cfg_pwdata[0]))
  ) else $error("unicode escape register write lost");

endmodule
